// File: rtl/nscf_pkg.sv
// Shared types, constants and codes of the non-crossing segment filter.
package nscf_pkg;

  // Coordinate width is fixed by the 12-bit coordinate fields of an item.
  localparam int COORD_BITS = 12;
  localparam int MAX_SEGMENTS_DEF = 64;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LIMIT_W    = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // Register index, taken from the word address bits of the configuration port.
  localparam logic REG_CAPACITY_LIMIT = 1'b0;

  // Result status codes.
  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_CROSS  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
  } seg_t;

  typedef struct packed {
    logic valid;
    logic crossed;
  } cross_res_t;

endpackage

// File: rtl/nscf_cell.sv
// One storage cell of the segment ring: holds one segment and passes it on.
module nscf_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  logic          load_en,
  input  nscf_pkg::seg_t nbr_seg,
  input  nscf_pkg::seg_t new_seg,
  output nscf_pkg::seg_t seg
);
  import nscf_pkg::*;

  seg_t seg_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      seg_r <= new_seg;
    end else if (shift_en) begin
      seg_r <= nbr_seg;
    end
  end

  assign seg = seg_r;

endmodule

// File: rtl/nscf_cross.sv
// Shared proper-crossing test of a stored segment against the candidate: products registered, compare combinational.
module nscf_cross (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  nscf_pkg::seg_t       stored,
  input  nscf_pkg::seg_t       cand,
  output nscf_pkg::cross_res_t res
);
  import nscf_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;

  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [PW-1:0] prod_t;

  function automatic diff_t cdiff(input logic [COORD_BITS-1:0] a,
                                  input logic [COORD_BITS-1:0] b);
    cdiff = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic prod_t mul(input diff_t a, input diff_t b);
    mul = prod_t'(a) * prod_t'(b);
  endfunction

  prod_t prod_nxt [8];
  prod_t prod_r   [8];
  logic  valid_r;
  logic  o_acd, o_bcd, o_abc, o_abd;

  // A, B are the stored endpoints; C, D the candidate's.
  // Each orientation compares lhs = (R.y-P.y)*(Q.x-P.x) with rhs = (Q.y-P.y)*(R.x-P.x).
  always_comb begin
    prod_nxt[0] = mul(cdiff(cand.by, stored.ay), cdiff(cand.ax, stored.ax));
    prod_nxt[1] = mul(cdiff(cand.ay, stored.ay), cdiff(cand.bx, stored.ax));
    prod_nxt[2] = mul(cdiff(cand.by, stored.by), cdiff(cand.ax, stored.bx));
    prod_nxt[3] = mul(cdiff(cand.ay, stored.by), cdiff(cand.bx, stored.bx));
    prod_nxt[4] = mul(cdiff(cand.ay, stored.ay), cdiff(stored.bx, stored.ax));
    prod_nxt[5] = mul(cdiff(stored.by, stored.ay), cdiff(cand.ax, stored.ax));
    prod_nxt[6] = mul(cdiff(cand.by, stored.ay), cdiff(stored.bx, stored.ax));
    prod_nxt[7] = mul(cdiff(stored.by, stored.ay), cdiff(cand.bx, stored.ax));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign o_acd = prod_r[0] > prod_r[1];
  assign o_bcd = prod_r[2] > prod_r[3];
  assign o_abc = prod_r[4] > prod_r[5];
  assign o_abd = prod_r[6] > prod_r[7];

  assign res.valid   = valid_r;
  assign res.crossed = (o_acd ^ o_bcd) & (o_abc ^ o_abd);

endmodule

// File: rtl/non_crossing_segment_filter.sv
// Top level of the non-crossing segment filter: control, segment ring and ports.
//
// Each item is a candidate segment that is tested, in store order, against every stored
// segment for a proper crossing (collinear segments do not cross, but touching segments
// may be counted as crossing). The stored segments sit in a ring of MAX_SEGMENTS cells
// that rotates by one cell per cycle while walking, past a single crossing test. An item
// is handled in steps: one full turn of the ring, the finish of the last test, the decision
// and result write, and the return to idle where the next item is taken; no new item is
// taken before that. A result that the receiver has not yet taken holds the decision step
// until it is taken. The result reports status (accepted, crossing, full), the first
// crossed index and the stored count. A non-crossing candidate is appended while the count
// is below capacity_limit (saturated at MAX_SEGMENTS). Reset empties the store.
module non_crossing_segment_filter #(
  parameter int MAX_SEGMENTS = nscf_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: start_x, start_y, end_x, end_y (12 bits each, from bit 0 up)
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [nscf_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: status (2), hit_index (6), count_after (7), one zero pad bit
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [nscf_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [nscf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [nscf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [nscf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import nscf_pkg::*;

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int LW    = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   step_r;
  logic [IDX_W-1:0]   pidx_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic               found_r;
  logic [CNT_W-1:0]   count_r;
  logic [LIMIT_W-1:0] cap_limit_r;
  logic               out_valid_r;
  logic [1:0]         status_r;
  logic [5:0]         hit_out_r;
  logic [6:0]         count_out_r;
  seg_t               cand_r;

  seg_t               ring [MAX_SEGMENTS];
  cross_res_t         res;

  logic               in_fire, out_free, cfg_wr, last_step, test_valid;
  logic [LW-1:0]      limit_ext, eff_limit, count_ext;
  logic               is_full, do_append, finish;
  logic [1:0]         status_nxt;
  logic [CNT_W-1:0]   count_nxt;
  logic [CNT_W+6:0]   count_wide;
  logic [IDX_W+5:0]   hit_wide;

  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign last_step  = (step_r == IDX_W'(MAX_SEGMENTS - 1));
  assign test_valid = (state_r == S_WALK) && (CNT_W'(step_r) < count_r);

  assign limit_ext = LW'(cap_limit_r);
  assign eff_limit = (limit_ext > LW'(MAX_SEGMENTS)) ? LW'(MAX_SEGMENTS) : limit_ext;
  assign count_ext = LW'(count_r);
  assign is_full   = (count_ext >= eff_limit);

  assign finish     = (state_r == S_DONE) && out_free;
  assign do_append  = finish && !found_r && !is_full;
  assign count_nxt  = do_append ? count_r + CNT_W'(1) : count_r;
  assign status_nxt = found_r ? ST_CROSS : (is_full ? ST_FULL : ST_ACCEPT);
  assign count_wide = (CNT_W + 7)'(count_nxt);
  assign hit_wide   = (IDX_W + 6)'(hit_idx_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_WALK;
      S_WALK:  if (last_step) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // The ring turns once per item: cell 0 holds entry k at walk step k.
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    nscf_cell u_cell (
      .clk      (clk),
      .shift_en (state_r == S_WALK),
      .load_en  (do_append && (count_r[IDX_W-1:0] == IDX_W'(i))),
      .nbr_seg  (ring[(i + 1) % MAX_SEGMENTS]),
      .new_seg  (cand_r),
      .seg      (ring[i])
    );
  end

  nscf_cross u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (test_valid),
    .stored   (ring[0]),
    .cand     (cand_r),
    .res      (res)
  );

  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                  (cfg_paddr[CFG_ADDR_W-1:2] == REG_CAPACITY_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      found_r     <= 1'b0;
      count_r     <= '0;
      cap_limit_r <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_wr) begin
        cap_limit_r <= cfg_pwdata[LIMIT_W-1:0];
      end
      if (in_fire) begin
        found_r <= 1'b0;
        step_r  <= '0;
      end else begin
        if (state_r == S_WALK) begin
          step_r <= step_r + IDX_W'(1);
        end
        // Only the first crossing in store order is kept.
        if (res.valid && res.crossed && !found_r) begin
          found_r <= 1'b1;
        end
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= step_r;
    if (in_fire) begin
      cand_r <= '{ax: in_tdata[11:0], ay: in_tdata[23:12],
                  bx: in_tdata[35:24], by: in_tdata[47:36]};
    end
    if (res.valid && res.crossed && !found_r) begin
      hit_idx_r <= pidx_r;
    end
    if (finish) begin
      status_r    <= status_nxt;
      hit_out_r   <= found_r ? hit_wide[5:0] : 6'd0;
      count_out_r <= count_wide[6:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, count_out_r, hit_out_r, status_r};

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_CAPACITY_LIMIT) ?
                      CFG_DATA_W'(cap_limit_r) : '0;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SEGMENTS))
    else $error("stored count exceeds the store size");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the decision step");

  a_grow_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |->
      (out_valid_r && status_r == ST_ACCEPT && count_r == $past(count_r) + CNT_W'(1)))
    else $error("store grew without an accepted item");

  a_test_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> CNT_W'(pidx_r) < count_r)
    else $error("crossing test ran on an unused entry");
`endif

endmodule
